// ===== rtl/bot_pkg.sv =====
// ----------------------------------------------------------------------------
// bot_pkg: shared types and codes of the bounded override table
// Row layout, result status codes, action codes and sequencer states.
// ----------------------------------------------------------------------------
package bot_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int KEY_W        = 16;
  localparam int VAL_W        = 32;
  localparam int STATUS_W     = 3;
  localparam int ROWS_W       = 5;

  // Action codes of an input item
  localparam logic ACT_SET    = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  // One stored row
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } row_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_REPLACED = 3'd0,
    ST_APPENDED = 3'd1,
    ST_FULL     = 3'd2,
    ST_REMOVED  = 3'd3,
    ST_ABSENT   = 3'd4
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_MOVE_RD,
    S_MOVE_WR
  } state_t;

endpackage

// ===== rtl/bot_store.sv =====
// ----------------------------------------------------------------------------
// bot_store: row memory of the override table
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bot_store
  import bot_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int AW       = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  row_t          wr_row,
  input  logic [AW-1:0] rd_addr,
  output row_t          rd_row
);

  row_t mem [CAPACITY];

  // Write one row when asked
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
  end

  // Read one row every cycle
  always_ff @(posedge clk) begin
    rd_row <= mem[rd_addr];
  end

endmodule

// ===== rtl/bounded_override_table.sv =====
// ----------------------------------------------------------------------------
// bounded_override_table: key/value table with swap-remove
// Unordered table of up to CAPACITY rows searched by one shared key compare.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with action, slot_key and entry_value while busy is low; the
//   item transfers at that clock edge and busy rises for the rest of its work.
//   The result (status, rows_in_use) is shown for exactly one cycle with done
//   high; the receiver cannot hold it off, so nothing ever stalls.
// Timing:
//   One row read per cycle feeds the single key comparator, pipelined over
//   the registered read. The search stops at the first row whose key
//   matches, or once every row in use has been read; an empty table skips
//   it. A remove that hits then reads the last row (S_MOVE_RD) and moves it
//   into the hole (S_MOVE_WR). The next item may start in the cycle done is
//   high.
// Reset:
//   rst (synchronous) empties the table and returns to idle. The row memory
//   is not cleared: only rows below the count are ever compared or moved.
// ----------------------------------------------------------------------------
module bounded_override_table
  import bot_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                action,
  input  logic [KEY_W-1:0]    slot_key,
  input  logic signed [VAL_W-1:0] entry_value,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic [ROWS_W-1:0]   rows_in_use
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  state_t            state, state_next;
  logic              act, act_next;
  logic [KEY_W-1:0]  key, key_next;
  logic [VAL_W-1:0]  val, val_next;
  logic [CW-1:0]     scan_idx, scan_idx_next;
  logic              cmp_vld, cmp_vld_next;
  logic [AW-1:0]     cmp_idx;
  logic              hit, hit_next;
  logic [AW-1:0]     hit_idx, hit_idx_next;
  logic [CW-1:0]     count, count_next;
  logic              done_next;
  status_t           status_next;

  logic              issue;
  logic              key_eq;
  logic [CW-1:0]     count_m1;
  logic [CW+4:0]     count_ext;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  row_t              wr_row;
  logic [AW-1:0]     rd_addr;
  row_t              rd_row;

  bot_store #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_row  (wr_row),
    .rd_addr (rd_addr),
    .rd_row  (rd_row)
  );

  // Shared key comparator and scan bounds
  assign key_eq   = (rd_row.key == key);
  assign issue    = (scan_idx < count);
  assign count_m1 = count - 1'b1;

  assign busy      = (state != S_IDLE);
  assign count_ext = (CW + 5)'(count);
  assign rows_in_use = count_ext[ROWS_W-1:0];

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      done    <= 1'b0;
      cmp_vld <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      done    <= done_next;
      cmp_vld <= cmp_vld_next;
    end
  end

  // Item and scan registers
  always_ff @(posedge clk) begin
    act      <= act_next;
    key      <= key_next;
    val      <= val_next;
    scan_idx <= scan_idx_next;
    cmp_idx  <= scan_idx[AW-1:0];
    hit      <= hit_next;
    hit_idx  <= hit_idx_next;
    status   <= status_next;
  end

  // Sequencer: scan, decide, optional move
  always_comb begin
    state_next    = state;
    act_next      = act;
    key_next      = key;
    val_next      = val;
    scan_idx_next = scan_idx;
    cmp_vld_next  = 1'b0;
    hit_next      = hit;
    hit_idx_next  = hit_idx;
    count_next    = count;
    done_next     = 1'b0;
    status_next   = status_t'(status);
    rd_addr       = scan_idx[AW-1:0];
    wr_en         = 1'b0;
    wr_addr       = hit_idx;
    wr_row        = '{key: key, value: val};

    unique case (state)
      S_IDLE: begin
        // Capture the item and start the search
        if (start) begin
          act_next      = action;
          key_next      = slot_key;
          val_next      = entry_value;
          scan_idx_next = '0;
          hit_next      = 1'b0;
          state_next    = (count == '0) ? S_DECIDE : S_SCAN;
        end
      end

      S_SCAN: begin
        // Issue the next row read, compare the row read last cycle
        if (issue) begin
          scan_idx_next = scan_idx + 1'b1;
          cmp_vld_next  = 1'b1;
        end
        if (cmp_vld && key_eq) begin
          hit_next     = 1'b1;
          hit_idx_next = cmp_idx;
          state_next   = S_DECIDE;
        end else if (!issue) begin
          state_next = S_DECIDE;
        end
      end

      S_DECIDE: begin
        if (act == ACT_SET) begin
          if (hit) begin
            // Overwrite the value in place
            wr_en       = 1'b1;
            wr_addr     = hit_idx;
            done_next   = 1'b1;
            status_next = ST_REPLACED;
            state_next  = S_IDLE;
          end else if (count == CW'(CAPACITY)) begin
            done_next   = 1'b1;
            status_next = ST_FULL;
            state_next  = S_IDLE;
          end else begin
            // Append at the end
            wr_en       = 1'b1;
            wr_addr     = count[AW-1:0];
            count_next  = count + 1'b1;
            done_next   = 1'b1;
            status_next = ST_APPENDED;
            state_next  = S_IDLE;
          end
        end else begin
          if (hit) begin
            state_next = S_MOVE_RD;
          end else begin
            done_next   = 1'b1;
            status_next = ST_ABSENT;
            state_next  = S_IDLE;
          end
        end
      end

      S_MOVE_RD: begin
        // Fetch the last row
        rd_addr    = count_m1[AW-1:0];
        state_next = S_MOVE_WR;
      end

      S_MOVE_WR: begin
        // Move the last row into the hole and shrink
        wr_en       = 1'b1;
        wr_addr     = hit_idx;
        wr_row      = rd_row;
        count_next  = count_m1;
        done_next   = 1'b1;
        status_next = ST_REMOVED;
        state_next  = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
